@@ rtl/gki_pkg.sv @@
// Package for the gait keyframe interpolator.
// Holds the sequencer state type, sizing constants, action codes, divider widths and the divider result struct.
// No dependencies.
`default_nettype none
package gki_pkg;
  localparam int NUM_LEGS_DEF   = 6;
  localparam int MAX_FRAMES_DEF = 16;
  localparam int DIV_DW         = 48;
  localparam int DIV_VW         = 32;
  localparam logic signed [31:0] TIME_MAX = 32'sh7FFF_FFFF;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_JUMP  = 2'd2;
  localparam logic [1:0] ACT_MOVE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_WALK, S_SETUP, S_FDIV, S_RDA, S_RDB, S_MAC, S_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DW-1:0]    quot;
    logic [DIV_VW-1:0]    rem;
  } div_res_t;
endpackage
`default_nettype wire

@@ rtl/gki_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on gki_pkg for widths and the result struct.
`default_nettype none
module gki_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [gki_pkg::DIV_DW-1:0] dividend,
  input  wire logic [gki_pkg::DIV_VW-1:0] divisor,
  output gki_pkg::div_res_t              res
);
  import gki_pkg::*;

  localparam int CW = $clog2(DIV_DW + 1);

  logic [DIV_VW:0]   rem;
  logic [DIV_DW-1:0] quot;
  logic [DIV_VW-1:0] dvs;
  logic [CW-1:0]     count;
  logic              busy;
  logic              done;
  logic [DIV_VW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem[DIV_VW-1:0], quot[DIV_DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        quot  <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        quot  <= {quot[DIV_DW-2:0], fits};
        count <= count + 1'b1;
        if (count == CW'(DIV_DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem[DIV_VW-1:0];
endmodule
`default_nettype wire

@@ rtl/gki_mac.sv @@
// Two-stage multiply-add for one slot: a + round((b - a) * f / 65536), saturated.
// Depends on gki_pkg for the saturation limit.
`default_nettype none
module gki_mac (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic [16:0]        f,
  output logic                    out_valid,
  output logic signed [31:0]      result
);
  import gki_pkg::*;

  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [31:0] a1;
  logic               v1;
  logic signed [51:0] sum;

  assign diff = 33'(b) - 33'(a);
  assign sum  = 52'(a1) + ((52'(prod) + 52'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    prod <= 51'(diff * $signed({1'b0, f}));
    a1   <= a;
    if (sum > 52'(TIME_MAX))
      result <= TIME_MAX;
    else if (sum < -52'(TIME_MAX) - 52'sd1)
      result <= -TIME_MAX - 32'sd1;
    else
      result <= sum[31:0];
  end
endmodule
`default_nettype wire

@@ rtl/gki_top_dummy_unused.sv @@
// Slot sequencing helper: maps a frame number and a slot number to a store address.
// Depends on nothing outside itself.
`default_nettype none
module gki_addr #(
  parameter int SLOTS = 30,
  parameter int AW    = 9,
  parameter int FW    = 4
) (
  input  wire logic [FW-1:0] frame,
  input  wire logic [5:0]    slot,
  output logic [AW-1:0]      addr
);
  assign addr = AW'(32'(frame) * SLOTS + 32'(slot));
endmodule
`default_nettype wire

@@ rtl/gait_keyframe_interpolator_core.sv @@
// Gait keyframe interpolator: looping keyframe player with linear interpolation.
// Slot writes and frame closes are taken in the idle state. A jump or move is accepted,
// then a move whose time wraps runs the serial wrap divide, the walk steps to the frame
// of the time, setup follows, then the serial factor divide when the frame length is non-zero,
// then per slot: two store reads, multiply-add issue, pipeline wait, output, plus output stalls.
// Reset (synchronous, rst high) clears frame count, loop total, time and frame.
`default_nettype none
module gait_keyframe_interpolator_core #(
  parameter int NUM_LEGS   = gki_pkg::NUM_LEGS_DEF,
  parameter int MAX_FRAMES = gki_pkg::MAX_FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: frame_index[3:0], slot_index[9:4], value[41:10], zero fill
  input  wire logic [47:0] s_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: out_slot[5:0], out_value[37:6], from_frame[41:38], to_frame[45:42], zero fill
  output logic [47:0]      m_tdata,
  output logic             m_tlast
);
  import gki_pkg::*;

  localparam int SLOTS = 4 * NUM_LEGS + 6;
  localparam int DEPTH = MAX_FRAMES * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int NW    = $clog2(MAX_FRAMES + 1);

  state_t state, state_next;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic signed [31:0] frame_start  [MAX_FRAMES];
  logic signed [31:0] frame_length [MAX_FRAMES];
  logic signed [31:0] loop_duration;
  logic [NW-1:0]      frames_closed;
  logic signed [31:0] play_time;
  logic [FW-1:0]      current_frame;

  logic signed [32:0] t;
  logic [FW-1:0]      c;
  logic [FW-1:0]      nx;
  logic               back;
  logic [5:0]         s;
  logic [16:0]        f;
  logic signed [31:0] a_val;
  logic [5:0]         o_slot;
  logic signed [31:0] o_value;
  logic               o_last;

  logic               div_go;
  logic [DIV_DW-1:0]  div_dvd;
  logic [DIV_VW-1:0]  div_dvs;
  div_res_t           div_res;
  logic               mac_go;
  logic               mac_valid;
  logic signed [31:0] mac_out;

  logic [3:0]         in_fi;
  logic [5:0]         in_si;
  logic signed [31:0] in_v;
  logic               acc;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b;
  logic signed [32:0] end_c;
  logic signed [32:0] t_move;
  logic [FW-1:0]      c_clamp;
  logic signed [32:0] e_off;
  logic signed [32:0] len_c;
  logic signed [32:0] room;
  logic signed [32:0] len_in;
  logic [31:0]        c_w;
  logic [31:0]        nx_w;
  logic               walk_go;

  assign in_fi = s_tdata[3:0];
  assign in_si = s_tdata[9:4];
  assign in_v  = s_tdata[41:10];
  assign acc   = s_tvalid && s_tready;

  gki_addr #(.SLOTS(SLOTS), .AW(AW), .FW(4)) u_waddr (
    .frame(in_fi), .slot(in_si), .addr(waddr));
  gki_addr #(.SLOTS(SLOTS), .AW(AW), .FW(FW)) u_aaddr (
    .frame(c), .slot(s), .addr(addr_a));
  gki_addr #(.SLOTS(SLOTS), .AW(AW), .FW(FW)) u_baddr (
    .frame(nx), .slot(s), .addr(addr_b));

  gki_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_dvd), .divisor(div_dvs),
    .res(div_res));

  gki_mac u_mac (
    .clk(clk), .rst(rst), .in_valid(mac_go), .a(a_val), .b(rdata), .f(f),
    .out_valid(mac_valid), .result(mac_out));

  assign end_c   = 33'(frame_start[c]) + 33'(frame_length[c]);
  assign len_c   = 33'(frame_length[c]);
  assign e_off   = t - 33'(frame_start[c]);
  assign t_move  = 33'(play_time) + 33'(in_v);
  assign c_clamp = (32'(current_frame) >= 32'(frames_closed)) ?
                   FW'(32'(frames_closed) - 1) : current_frame;
  assign room    = 33'(TIME_MAX) - 33'(loop_duration);
  assign len_in  = (in_v < 0) ? 33'sd0 : 33'(in_v);
  assign c_w     = 32'(c);
  assign nx_w    = 32'(nx);
  assign walk_go = back ? (c_w > 0 && t < 33'(frame_start[c]))
                        : (c_w + 1 < 32'(frames_closed) && t > end_c);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && frames_closed != '0 &&
            (s_tuser == ACT_JUMP || (s_tuser == ACT_MOVE && in_v != 0))) begin
          if (s_tuser == ACT_MOVE && loop_duration != 0 &&
              ((in_v > 0 && t_move > 33'(loop_duration)) || (in_v < 0 && t_move < 0)))
            state_next = S_WRAP;
          else
            state_next = S_WALK;
        end
      end
      S_WRAP:  if (div_res.done) state_next = S_WALK;
      S_WALK:  if (!walk_go) state_next = S_SETUP;
      S_SETUP: state_next = (frame_length[c] > 0) ? S_FDIV : S_RDA;
      S_FDIV:  if (div_res.done) state_next = S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_MAC;
      S_MAC:   state_next = S_WAIT;
      S_WAIT:  if (mac_valid) state_next = S_OUT;
      S_OUT: begin
        if (m_tready) state_next = o_last ? S_IDLE : S_RDA;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    mac_go   = 1'b0;
    raddr    = addr_a;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_RDB:  raddr    = addr_b;
      S_MAC:  mac_go   = 1'b1;
      S_OUT:  m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && s_tuser == ACT_WRITE && 32'(in_fi) < MAX_FRAMES && 32'(in_si) < SLOTS)
      mem[waddr] <= in_v;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      loop_duration <= '0;
      frames_closed <= '0;
      play_time     <= '0;
      current_frame <= '0;
      div_go        <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc && s_tuser == ACT_CLOSE && 32'(frames_closed) < MAX_FRAMES) begin
            frame_start[FW'(frames_closed)]  <= loop_duration;
            frame_length[FW'(frames_closed)] <= (len_in > room) ? room[31:0] : len_in[31:0];
            loop_duration <= (len_in > room) ? TIME_MAX : loop_duration + len_in[31:0];
            frames_closed <= frames_closed + 1'b1;
          end
          if (s_tuser == ACT_JUMP) begin
            back <= 1'b0;
            c    <= '0;
            if (in_v < 0)
              t <= '0;
            else if (in_v > loop_duration)
              t <= 33'(loop_duration);
            else
              t <= 33'(in_v);
          end else begin
            back    <= in_v < 0;
            c       <= c_clamp;
            t       <= t_move;
            div_dvs <= loop_duration;
            if (in_v > 0 && t_move > 33'(loop_duration)) begin
              c       <= '0;
              t       <= '0;
              div_dvd <= DIV_DW'(t_move - 33'sd1);
            end else if (in_v < 0 && t_move < 0) begin
              c       <= FW'(32'(frames_closed) - 1);
              t       <= '0;
              div_dvd <= DIV_DW'(-t_move);
            end
          end
          if (state_next == S_WRAP)
            div_go <= 1'b1;
        end
        S_WRAP: begin
          if (div_res.done) begin
            if (back)
              t <= (div_res.rem == '0) ? 33'sd0 : 33'(loop_duration) - 33'(div_res.rem);
            else
              t <= 33'(div_res.rem) + 33'sd1;
          end
        end
        S_WALK: begin
          if (walk_go)
            c <= back ? c - 1'b1 : c + 1'b1;
        end
        S_SETUP: begin
          play_time     <= t[31:0];
          current_frame <= c;
          nx            <= (c_w + 1 == 32'(frames_closed)) ? '0 : c + 1'b1;
          s             <= '0;
          f             <= '0;
          div_dvs       <= frame_length[c];
          if (e_off < 0)
            div_dvd <= '0;
          else if (e_off > len_c)
            div_dvd <= {len_c[31:0], 16'd0};
          else
            div_dvd <= {e_off[31:0], 16'd0};
          if (frame_length[c] > 0)
            div_go <= 1'b1;
        end
        S_FDIV: if (div_res.done) f <= div_res.quot[16:0];
        S_RDB:  a_val <= rdata;
        S_WAIT: begin
          if (mac_valid) begin
            o_slot  <= s;
            o_value <= mac_out;
            o_last  <= 32'(s) == SLOTS - 1;
          end
        end
        S_OUT:  if (m_tready) s <= s + 1'b1;
        default: ;
      endcase
    end
  end

  assign m_tdata = {2'b00, nx_w[3:0], c_w[3:0], o_value, o_slot};
  assign m_tlast = o_last;

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while a result is pending");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("sequencer did not return to idle after the final slot");
  a_frame_in_range: assert property (@(posedge clk) disable iff (rst)
    (s_tready && frames_closed != '0) |-> (32'(current_frame) < 32'(frames_closed)))
    else $error("current frame beyond the closed frames");
endmodule
`default_nettype wire
